### hdl/rsr_pkg.sv
// Shared types, constants and codes for the replacement-selection run generator.
package rsr_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int KEY_FIELD_W  = 32;
    localparam int PAY_W        = 64;
    localparam int RUN_W        = 16;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [KEY_FIELD_W-1:0] record_key;
        logic [PAY_W-1:0]       record_payload;
    } rsr_in_t;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] out_key;
        logic [PAY_W-1:0]       out_payload;
        logic [RUN_W-1:0]       run_index;
        logic                   run_end;
        logic                   last;
    } rsr_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT
    } rsr_state_t;

    typedef struct packed {
        logic take;
        logic fill;
        logic scan_start;
        logic emit;
    } rsr_cmd_t;

    typedef struct packed {
        logic flush;
        logic full;
        logic empty;
        logic scan_done;
        logic out_free;
        logic flush_last;
    } rsr_status_t;

endpackage

### hdl/rsr_if.sv
// Request channel interfaces for records in and results out.
interface rsr_in_if;
    import rsr_pkg::*;
    logic    valid;
    logic    ready;
    rsr_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rsr_out_if;
    import rsr_pkg::*;
    logic     valid;
    logic     ready;
    rsr_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/replacement_selection_runs.sv
// Top level of the replacement-selection run generator.
//
// Channels: records (sink) carries action, record_key, record_payload; results
// (source) carries out_key, out_payload, run_index, run_end, last. A request
// moves when valid and ready are both high at a rising clock edge.
// A push while the store holds fewer than SLOTS records is stored and gives
// no result. A push into a full store runs a comparator scan over all SLOTS
// entries, one memory read per cycle: the result is then loaded into the
// output register, and records is ready again in the cycle after that.
// A flush emits every stored record, one scan per record; the current run
// comes first, then the frozen records as a final run. A flush of an empty
// store gives no result.
// The output register lets the next request be accepted while a result
// waits; if results stalls, the block holds in its emit step until the
// register is free. Reset clears all occupancy and frozen flags at once;
// there is no clearing pass.
module replacement_selection_runs #(
    parameter int SLOTS    = rsr_pkg::SLOTS_DEF,
    parameter int KEY_BITS = rsr_pkg::KEY_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    rsr_in_if.sink    records,
    rsr_out_if.source results
);
    import rsr_pkg::*;

    rsr_cmd_t    cmd;
    rsr_status_t status;

    rsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (records.valid),
        .req_ready (records.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsr_datapath #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_data  (records.payload),
        .res_ready (results.ready),
        .res_valid (results.valid),
        .res_data  (results.payload)
    );

endmodule

### hdl/rsr_ctrl.sv
// Controller state machine: sequences fill, minimum scan and emission.
module rsr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  rsr_pkg::rsr_status_t status,
    output rsr_pkg::rsr_cmd_t    cmd
);
    import rsr_pkg::*;

    rsr_state_t state_reg;
    rsr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.flush)
                begin
                    if (status.empty)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
                else if (status.full)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    cmd.fill   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.flush && !status.flush_last)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/rsr_datapath.sv
// Datapath: record store, sequential minimum scan, counters and output register.
module rsr_datapath #(
    parameter int SLOTS    = rsr_pkg::SLOTS_DEF,
    parameter int KEY_BITS = rsr_pkg::KEY_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rsr_pkg::rsr_cmd_t    cmd,
    output rsr_pkg::rsr_status_t status,
    input  rsr_pkg::rsr_in_t     req_data,
    input  logic                 res_ready,
    output logic                 res_valid,
    output rsr_pkg::rsr_out_t    res_data
);
    import rsr_pkg::*;

    localparam int KEY_W = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [PAY_W-1:0] pay_mem [SLOTS];

    logic             in_flush_reg;
    logic [KEY_W-1:0] in_key_reg;
    logic [PAY_W-1:0] in_pay_reg;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] unfrozen_reg, unfrozen_next;
    logic [SLOTS-1:0] occ_reg, occ_next;
    logic [SLOTS-1:0] frz_reg, frz_next;
    logic [RUN_W-1:0] run_reg, run_next;

    logic [IDX_W-1:0] scan_idx_reg;
    logic             issue_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic [PAY_W-1:0] rd_pay_reg;

    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [PAY_W-1:0] best_pay_reg;

    logic             out_valid_reg;
    rsr_out_t         out_data_reg;

    logic             want;
    logic             cand;
    logic             better;
    logic             new_frozen;
    logic             flush_last;
    logic             run_end;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] fill_idx;

    // frozen group is drained once the unfrozen group is empty
    assign want       = in_flush_reg && (unfrozen_reg == '0);
    assign cand       = rd_valid_reg && occ_reg[rd_idx_reg] && (frz_reg[rd_idx_reg] == want);
    assign better     = cand && (!found_reg || (rd_key_reg < best_key_reg));
    assign new_frozen = in_key_reg < best_key_reg;
    assign flush_last = fill_reg == ONE_CNT;
    assign run_end    = in_flush_reg ? (want ? flush_last : (unfrozen_reg == ONE_CNT))
                                     : ((unfrozen_reg == ONE_CNT) && new_frozen);
    assign fill_idx   = fill_reg[IDX_W-1:0];
    assign wr_en      = cmd.fill || (cmd.emit && !in_flush_reg);
    assign wr_addr    = cmd.fill ? fill_idx : best_idx_reg;

    assign status.flush      = in_flush_reg;
    assign status.full       = fill_reg == FULL_CNT;
    assign status.empty      = fill_reg == '0;
    assign status.scan_done  = !issue_reg && !rd_valid_reg;
    assign status.out_free   = !out_valid_reg || res_ready;
    assign status.flush_last = flush_last;

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= in_key_reg;
            pay_mem[wr_addr] <= in_pay_reg;
        end
        rd_key_reg <= key_mem[scan_idx_reg];
        rd_pay_reg <= pay_mem[scan_idx_reg];
    end

    always_comb
    begin
        occ_next      = occ_reg;
        frz_next      = frz_reg;
        fill_next     = fill_reg;
        unfrozen_next = unfrozen_reg;
        run_next      = run_reg;
        if (cmd.fill)
        begin
            occ_next[fill_idx] = 1'b1;
            frz_next[fill_idx] = 1'b0;
            fill_next          = fill_reg + ONE_CNT;
            unfrozen_next      = unfrozen_reg + ONE_CNT;
        end
        if (cmd.emit)
        begin
            if (run_end)
            begin
                run_next = run_reg + RUN_W'(1);
            end
            if (!in_flush_reg)
            begin
                if (run_end)
                begin
                    frz_next      = '0;
                    unfrozen_next = fill_reg;
                end
                else if (new_frozen)
                begin
                    frz_next[best_idx_reg] = 1'b1;
                    unfrozen_next          = unfrozen_reg - ONE_CNT;
                end
            end
            else
            begin
                occ_next[best_idx_reg] = 1'b0;
                fill_next              = fill_reg - ONE_CNT;
                if (!want)
                begin
                    unfrozen_next = unfrozen_reg - ONE_CNT;
                end
                if (flush_last)
                begin
                    frz_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            unfrozen_reg  <= '0;
            occ_reg       <= '0;
            frz_reg       <= '0;
            run_reg       <= '0;
            in_flush_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            issue_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            unfrozen_reg <= unfrozen_next;
            occ_reg      <= occ_next;
            frz_reg      <= frz_next;
            run_reg      <= run_next;
            if (cmd.take)
            begin
                in_flush_reg <= req_data.action == ACT_FLUSH;
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                issue_reg    <= 1'b1;
            end
            else if (issue_reg)
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
            end
            rd_valid_reg <= issue_reg;
            if (cmd.scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            in_key_reg <= req_data.record_key[KEY_W-1:0];
            in_pay_reg <= req_data.record_payload;
        end
        rd_idx_reg <= scan_idx_reg;
        if (better)
        begin
            best_idx_reg <= rd_idx_reg;
            best_key_reg <= rd_key_reg;
            best_pay_reg <= rd_pay_reg;
        end
        if (cmd.emit)
        begin
            out_data_reg.out_key     <= KEY_FIELD_W'(best_key_reg);
            out_data_reg.out_payload <= best_pay_reg;
            out_data_reg.run_index   <= run_reg;
            out_data_reg.run_end     <= run_end;
            out_data_reg.last        <= in_flush_reg ? flush_last : 1'b1;
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count above store depth");
    a_unfrozen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        unfrozen_reg <= fill_reg)
        else $error("unfrozen count above fill count");
    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> found_reg)
        else $error("emit without a selected slot");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || res_ready))
        else $error("emit overwrote a pending result");
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !in_flush_reg) |-> (fill_reg == FULL_CNT))
        else $error("push emitted from a partly filled store");
`endif

endmodule

### dv/tb_replacement_selection_runs.sv
// Testbench for the replacement-selection run generator: directed and random record streams.
module tb_replacement_selection_runs;
    import rsr_pkg::*;

    localparam int SLOTS    = SLOTS_DEF;
    localparam int KEY_BITS = KEY_BITS_DEF;
    localparam logic [KEY_FIELD_W-1:0] KEY_MASK = (KEY_BITS >= KEY_FIELD_W) ? '1 :
        KEY_FIELD_W'((64'd1 << KEY_BITS) - 64'd1);
    localparam int RANDOM_ITEMS = 430;

    logic clk;
    logic rst_n;

    rsr_in_if  rec_if ();
    rsr_out_if res_if ();

    replacement_selection_runs #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .records (rec_if),
        .results (res_if)
    );

    // store image
    logic [KEY_FIELD_W-1:0] store_key    [SLOTS];
    logic [PAY_W-1:0]       store_pay    [SLOTS];
    bit                     store_frozen [SLOTS];
    bit                     store_used   [SLOTS];
    int                     store_fill;
    logic [RUN_W-1:0]       run_no;

    rsr_out_t pending_results [$];

    int  errors;
    int  requests_sent;
    int  flushes_sent;
    int  records_seen;
    int  runs_closed;
    int  stall_left;
    bit  idle_off;
    logic [KEY_FIELD_W-1:0] walk_key;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 700000);
        $display("[replacement_selection_runs] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int find_smallest(bit want_frozen);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (store_used[i] && store_frozen[i] == want_frozen)
            begin
                if (best < 0 || store_key[i] < store_key[best])
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic void clear_frozen();
        for (int i = 0; i < SLOTS; i++)
            store_frozen[i] = 1'b0;
    endfunction

    function automatic void predict_request(rsr_in_t req);
        logic [KEY_FIELD_W-1:0] k;
        logic [KEY_FIELD_W-1:0] gone;
        int       s;
        int       n;
        int       grp;
        bit       all_frozen;
        rsr_out_t r;
        rsr_out_t batch [SLOTS];
        k = req.record_key & KEY_MASK;
        if (req.action == ACT_PUSH)
        begin
            if (store_fill < SLOTS)
            begin
                store_key[store_fill]    = k;
                store_pay[store_fill]    = req.record_payload;
                store_frozen[store_fill] = 1'b0;
                store_used[store_fill]   = 1'b1;
                store_fill++;
                return;
            end
            s = find_smallest(1'b0);
            if (s < 0)
            begin
                clear_frozen();
                s = find_smallest(1'b0);
                if (s < 0)
                    return;
            end
            gone          = store_key[s];
            r.out_key     = gone;
            r.out_payload = store_pay[s];
            r.run_index   = run_no;
            r.run_end     = 1'b0;
            r.last        = 1'b1;
            store_key[s]    = k;
            store_pay[s]    = req.record_payload;
            store_frozen[s] = (k < gone);
            all_frozen = 1'b1;
            for (int i = 0; i < SLOTS; i++)
                if (store_used[i] && !store_frozen[i])
                    all_frozen = 1'b0;
            if (all_frozen)
            begin
                r.run_end = 1'b1;
                clear_frozen();
                run_no = run_no + 1'b1;
                runs_closed++;
            end
            pending_results.push_back(r);
            return;
        end
        // flush: current run, then frozen records as a final run
        n = 0;
        for (int pass = 0; pass < 2; pass++)
        begin
            grp = 0;
            s = find_smallest(pass == 1);
            while (n < SLOTS && s >= 0)
            begin
                batch[n].out_key     = store_key[s];
                batch[n].out_payload = store_pay[s];
                batch[n].run_index   = run_no;
                batch[n].run_end     = 1'b0;
                batch[n].last        = 1'b0;
                store_used[s] = 1'b0;
                n++;
                grp++;
                s = find_smallest(pass == 1);
            end
            if (grp > 0)
            begin
                batch[n-1].run_end = 1'b1;
                run_no = run_no + 1'b1;
                runs_closed++;
            end
        end
        if (n > 0)
            batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_results.push_back(batch[i]);
        for (int i = 0; i < SLOTS; i++)
        begin
            store_frozen[i] = 1'b0;
            store_used[i]   = 1'b0;
        end
        store_fill = 0;
    endfunction

    task automatic compare_result(rsr_out_t got);
        rsr_out_t exp;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result key=%h payload=%h run=%0d", $time,
                     got.out_key, got.out_payload, got.run_index);
            errors++;
            return;
        end
        exp = pending_results.pop_front();
        records_seen++;
        if (got.out_key !== exp.out_key)
        begin
            $display("%0t: out_key expected %h actual %h", $time, exp.out_key, got.out_key);
            errors++;
        end
        if (got.out_payload !== exp.out_payload)
        begin
            $display("%0t: out_payload expected %h actual %h", $time,
                     exp.out_payload, got.out_payload);
            errors++;
        end
        if (got.run_index !== exp.run_index)
        begin
            $display("%0t: run_index expected %0d actual %0d", $time,
                     exp.run_index, got.run_index);
            errors++;
        end
        if (got.run_end !== exp.run_end)
        begin
            $display("%0t: run_end expected %b actual %b", $time, exp.run_end, got.run_end);
            errors++;
        end
        if (got.last !== exp.last)
        begin
            $display("%0t: last expected %b actual %b", $time, exp.last, got.last);
            errors++;
        end
    endtask

    // result side: random back-pressure and checking
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
                compare_result(res_if.payload);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (!idle_off && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                res_if.ready <= (stall_left == 0);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic send_request(input logic act, input logic [KEY_FIELD_W-1:0] key,
                                input logic [PAY_W-1:0] pay);
        int      gap;
        rsr_in_t req;
        req.action         = act;
        req.record_key     = key;
        req.record_payload = pay;
        gap = idle_off ? 0 : pick_gap();
        if (gap > 0)
        begin
            rec_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec_if.valid   <= 1'b1;
        rec_if.payload <= req;
        do
            @(posedge clk);
        while (rec_if.ready !== 1'b1);
        predict_request(req);
        requests_sent++;
        if (act == ACT_FLUSH)
            flushes_sent++;
    endtask

    task automatic test_flush_edges();
        send_request(ACT_FLUSH, 32'h0, 64'h0);
        send_request(ACT_PUSH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_PUSH, 32'd7, 64'h1111_2222_3333_4444);
        send_request(ACT_PUSH, 32'd7, 64'h5555_6666_7777_8888);
        send_request(ACT_PUSH, 32'd0, 64'h0);
        send_request(ACT_FLUSH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_full_store();
        logic [KEY_FIELD_W-1:0] k;
        for (int i = 0; i < SLOTS; i++)
        begin
            k = (i == SLOTS - 1) ? 32'hFFFF_FFFF : KEY_FIELD_W'(i) << 28;
            send_request(ACT_PUSH, k, (i % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
        end
        send_request(ACT_PUSH, 32'h0, 64'hA5A5_A5A5_5A5A_5A5A);
        send_request(ACT_PUSH, 32'hFFFF_FFFF, 64'h0);
        send_request(ACT_PUSH, 32'h1, {$urandom, $urandom});
        send_request(ACT_FLUSH, 32'h0, 64'h0);
    endtask

    function automatic logic [KEY_FIELD_W-1:0] next_key(int mode);
        case (mode)
            1: return $urandom_range(0, 7);
            2:
            begin
                walk_key = walk_key - $urandom_range(1, 1000);
                return walk_key;
            end
            3:
            begin
                walk_key = walk_key + $urandom_range(1, 1000);
                return walk_key;
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h0;
                    1: return 32'h1;
                    2: return 32'hFFFF_FFFE;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_runs();
        int mode;
        int fill_n;
        int extra;
        int r;
        while (requests_sent < RANDOM_ITEMS)
        begin
            idle_off = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            mode = (r < 3) ? 2 : (r < 6) ? 0 : (r < 7) ? 1 : (r < 8) ? 3 : 4;
            walk_key = (mode == 2) ? 32'hF000_0000 + $urandom_range(0, 65535) :
                                     $urandom_range(0, 65535);
            fill_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SLOTS - 1) : SLOTS;
            extra  = (fill_n == SLOTS) ? $urandom_range(0, 40) : 0;
            for (int i = 0; i < fill_n + extra; i++)
                send_request(ACT_PUSH, next_key(mode), {$urandom, $urandom});
            send_request(ACT_FLUSH, $urandom, {$urandom, $urandom});
            if ($urandom_range(0, 7) == 0)
                send_request(ACT_FLUSH, $urandom, {$urandom, $urandom});
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        rec_if.valid   <= 1'b0;
        rec_if.payload <= '0;
        errors        = 0;
        requests_sent = 0;
        flushes_sent  = 0;
        records_seen  = 0;
        runs_closed   = 0;
        stall_left    = 0;
        idle_off      = 1'b0;
        store_fill    = 0;
        run_no        = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            store_frozen[i] = 1'b0;
            store_used[i]   = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_flush_edges();
        test_full_store();
        test_random_runs();

        rec_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * SLOTS + 20) @(posedge clk);

        $display("covered %0d requests (%0d flushes), %0d records emitted in %0d runs",
                 requests_sent, flushes_sent, records_seen, runs_closed);
        if (errors == 0)
            $display("[replacement_selection_runs] OK");
        else
            $display("[replacement_selection_runs] ERROR");
        $finish;
    end

endmodule
